// ===== hw/rtl/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by the channel interfaces and the top level.
package utf8d_pkg;

	localparam int BYTE_W = 8;
	localparam int UNIT_W = 16;

	localparam logic [UNIT_W-1:0] REPLACEMENT = 16'hFFFD;

	// Length of the sequence currently being assembled.
	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	// Top five bits of a three-byte code point that mark a surrogate.
	localparam logic [4:0] SURROGATE_TOP = 5'b11011;

	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              decode_error;
		logic              last_of_run;
	} result_t;

endpackage

// ===== hw/rtl/utf8d_byte_if.sv =====
// Input channel of the decoder: one UTF-8 byte or an end-of-stream mark.
// Depends on utf8d_pkg for the byte width.
interface utf8d_byte_if;
	import utf8d_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_value;
	logic              end_of_stream;

	modport source (output valid, output byte_value, output end_of_stream, input ready);
	modport sink (input valid, input byte_value, input end_of_stream, output ready);
endinterface

// ===== hw/rtl/utf8d_unit_if.sv =====
// Output channel of the decoder: one UTF-16 code unit with its flags.
// Depends on utf8d_pkg for the code unit width.
interface utf8d_unit_if;
	import utf8d_pkg::*;

	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              decode_error;
	logic              last_of_run;

	modport source (output valid, output code_unit, output decode_error, output last_of_run,
		input ready);
	modport sink (input valid, input code_unit, input decode_error, input last_of_run,
		output ready);
endinterface

// ===== hw/rtl/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 (BMP only) decoder with U+FFFD replacement.
// Depends on utf8d_pkg, utf8d_byte_if and utf8d_unit_if.
//
// in_ch carries one byte per transaction, or an end-of-stream mark that
// flushes a pending sequence. out_ch carries decoded code units; the last
// result caused by an input transaction has last_of_run set. An input can
// cause zero, one or two results.
//
// Each accepted byte is decoded in the cycle it is taken, against the
// sequence state registers, and its results are written into a four-entry
// result queue, from which out_ch is driven once the results ahead have
// been taken. The block takes one byte per cycle while the queue has room
// for two results, so inputs that cause at most one result flow at one per
// cycle; a run of two-result inputs is held to the output rate of one
// result per cycle by that queue.
//
// When the receiver stalls, the queue fills and in_ch.ready drops until
// the queue holds two results or fewer. After a four-byte sequence the
// block reports an error and then drops every input until reset. Reset
// empties the queue and clears all sequence state.
module utf8_to_utf16_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	utf8d_byte_if.sink           in_ch,
	utf8d_unit_if.source         out_ch
);
	import utf8d_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		logic              emit;
		logic [UNIT_W-1:0] code_unit;
		logic [2:0]        exp_len;
		logic [1:0]        seen;
		logic [UNIT_W-1:0] partial;
		logic              skip;
	} lead_t;

	function automatic lead_t take_lead(input logic [BYTE_W-1:0] b);
		lead_t r;
		r = '0;
		r.exp_len = LEN_NONE;
		if (b < 8'h80) begin
			r.emit = 1'b1;
			r.code_unit = (b != 8'h00) ? {8'h00, b} : REPLACEMENT;
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			r.exp_len = LEN_TWO;
			r.seen = 2'd1;
			r.partial = {11'd0, b[4:0]};
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			r.exp_len = LEN_THREE;
			r.seen = 2'd1;
			r.partial = {12'd0, b[3:0]};
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			r.exp_len = LEN_FOUR;
			r.seen = 2'd1;
		end else begin
			r.emit = 1'b1;
			r.code_unit = REPLACEMENT;
			r.skip = 1'b1;
		end
		return r;
	endfunction

	// Sequence state.
	logic [2:0]        exp_len_q;
	logic [1:0]        seen_q;
	logic [UNIT_W-1:0] partial_q;
	logic              skip_q;
	logic              halted_q;

	// Result queue.
	result_t           queue_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	logic              in_fire;
	logic              out_fire;
	logic [BYTE_W-1:0] b;
	logic              cont;
	lead_t             lead;

	logic              pre_emit;
	logic [UNIT_W-1:0] pre_unit;
	logic              pre_err;
	logic              do_lead;
	logic [2:0]        exp_len_d;
	logic [1:0]        seen_d;
	logic [UNIT_W-1:0] partial_d;
	logic              skip_d;
	logic              halted_d;
	logic [15:0]       cp3;

	logic [1:0]        n_res;
	result_t           res0;
	result_t           res1;

	assign in_ch.ready = (count_q <= CNT_W'(DEPTH - 2));
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (count_q != '0);
	assign out_fire    = out_ch.valid && out_ch.ready;

	assign out_ch.code_unit    = queue_q[rd_ptr_q].code_unit;
	assign out_ch.decode_error = queue_q[rd_ptr_q].decode_error;
	assign out_ch.last_of_run  = queue_q[rd_ptr_q].last_of_run;

	assign b    = in_ch.byte_value;
	assign cont = (b[7:6] == 2'b10);
	assign lead = take_lead(b);
	assign cp3  = {partial_q[3:0], b[5:0], 6'd0};

	always_comb begin
		pre_emit  = 1'b0;
		pre_unit  = REPLACEMENT;
		pre_err   = 1'b0;
		do_lead   = 1'b0;
		exp_len_d = exp_len_q;
		seen_d    = seen_q;
		partial_d = partial_q;
		skip_d    = skip_q;
		halted_d  = halted_q;

		if (halted_q) begin
			// Everything is dropped until reset.
		end else if (in_ch.end_of_stream) begin
			pre_emit  = (exp_len_q != LEN_NONE);
			exp_len_d = LEN_NONE;
			seen_d    = '0;
			partial_d = '0;
			skip_d    = 1'b0;
		end else if (skip_q) begin
			if (!cont) begin
				do_lead = 1'b1;
			end
		end else begin
			case (exp_len_q)
				LEN_TWO: begin
					if (cont) begin
						pre_emit  = 1'b1;
						pre_unit  = {5'd0, partial_q[4:0], b[5:0]};
						exp_len_d = LEN_NONE;
						seen_d    = '0;
						partial_d = '0;
					end else begin
						pre_emit = 1'b1;
						do_lead  = 1'b1;
					end
				end
				LEN_THREE: begin
					if (!cont) begin
						pre_emit = 1'b1;
						do_lead  = 1'b1;
					end else if (seen_q == 2'd1) begin
						// Overlong forms and surrogates are rejected on the second byte.
						if (cp3[15:11] == 5'd0 || cp3[15:11] == SURROGATE_TOP) begin
							pre_emit  = 1'b1;
							exp_len_d = LEN_NONE;
							seen_d    = '0;
							partial_d = '0;
							skip_d    = 1'b1;
						end else begin
							partial_d = cp3;
							seen_d    = 2'd2;
						end
					end else begin
						pre_emit  = 1'b1;
						pre_unit  = {partial_q[15:6], b[5:0]};
						exp_len_d = LEN_NONE;
						seen_d    = '0;
						partial_d = '0;
					end
				end
				LEN_FOUR: begin
					if (seen_q == 2'd3) begin
						pre_emit  = 1'b1;
						pre_unit  = '0;
						pre_err   = 1'b1;
						exp_len_d = LEN_NONE;
						seen_d    = '0;
						partial_d = '0;
						halted_d  = 1'b1;
					end else begin
						seen_d = seen_q + 2'd1;
					end
				end
				default: begin
					do_lead = 1'b1;
				end
			endcase
		end

		if (do_lead) begin
			exp_len_d = lead.exp_len;
			seen_d    = lead.seen;
			partial_d = lead.partial;
			skip_d    = lead.skip;
		end
	end

	always_comb begin
		res0 = '0;
		res1 = '0;
		n_res = 2'd0;
		if (pre_emit && do_lead && lead.emit) begin
			n_res = 2'd2;
			res0 = '{code_unit: pre_unit, decode_error: pre_err, last_of_run: 1'b0};
			res1 = '{code_unit: lead.code_unit, decode_error: 1'b0, last_of_run: 1'b1};
		end else if (pre_emit) begin
			n_res = 2'd1;
			res0 = '{code_unit: pre_unit, decode_error: pre_err, last_of_run: 1'b1};
		end else if (do_lead && lead.emit) begin
			n_res = 2'd1;
			res0 = '{code_unit: lead.code_unit, decode_error: 1'b0, last_of_run: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= LEN_NONE;
			seen_q    <= '0;
			partial_q <= '0;
			skip_q    <= 1'b0;
			halted_q  <= 1'b0;
		end else if (in_fire) begin
			exp_len_q <= exp_len_d;
			seen_q    <= seen_d;
			partial_q <= partial_d;
			skip_q    <= skip_d;
			halted_q  <= halted_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_fire) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (in_fire ? CNT_W'(n_res) : CNT_W'(0))
				- (out_fire ? CNT_W'(1) : CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
			if (n_res == 2'd2) begin
				queue_q[wr_ptr_q + PTR_W'(1)] <= res1;
			end
		end
	end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 decoder: directed cases, random streams,
// an output stall and the four-byte halt, each checked against an in-bench decoder model.
// Depends on utf8d_pkg, utf8d_byte_if, utf8d_unit_if and utf8_to_utf16_decoder.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import utf8d_pkg::*;

	localparam int RESET_CYCLES   = 6;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 8;

	logic clk = 1'b0;
	logic arst_n;

	utf8d_byte_if in_if ();
	utf8d_unit_if out_if ();

	utf8_to_utf16_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Decoder model state.
	logic [2:0]  seq_len;
	logic [1:0]  seq_count;
	logic [15:0] seq_bits;
	bit          skip_cont;
	bit          stopped;
	result_t     step_units [2];
	int          step_n;
	result_t     pending_units [$];

	int  mismatches;
	int  sent_items;
	int  idle_cycles;
	int  src_idle;
	int  sink_idle;
	int  hold_reqs;
	int  hold_seen;
	int  hold_left;
	bit  halt_allowed;
	result_t oldest;

	function automatic void emit_unit(logic [15:0] cu, logic err);
		step_units[step_n] = '{code_unit: cu, decode_error: err, last_of_run: 1'b0};
		step_n++;
	endfunction

	function automatic void clear_seq();
		seq_len   = LEN_NONE;
		seq_count = 2'd0;
		seq_bits  = 16'h0000;
	endfunction

	function automatic void start_seq(logic [7:0] b);
		clear_seq();
		if (b < 8'h80) begin
			emit_unit((b == 8'h00) ? REPLACEMENT : {8'h00, b}, 1'b0);
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			seq_len   = LEN_TWO;
			seq_count = 2'd1;
			seq_bits  = {11'd0, b[4:0]};
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			seq_len   = LEN_THREE;
			seq_count = 2'd1;
			seq_bits  = {12'd0, b[3:0]};
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			seq_len   = LEN_FOUR;
			seq_count = 2'd1;
		end else begin
			emit_unit(REPLACEMENT, 1'b0);
			skip_cont = 1'b1;
		end
	endfunction

	// Works out the code units that one accepted transaction causes and queues them.
	function automatic void predict_units(logic [7:0] b, logic eos);
		logic        cont;
		logic [15:0] cp;
		result_t     r;
		cont   = (b[7:6] == 2'b10);
		step_n = 0;
		if (stopped)
			return;
		if (eos) begin
			if (seq_len != LEN_NONE)
				emit_unit(REPLACEMENT, 1'b0);
			clear_seq();
			skip_cont = 1'b0;
		end else if (skip_cont) begin
			if (!cont) begin
				skip_cont = 1'b0;
				start_seq(b);
			end
		end else if (seq_len == LEN_TWO) begin
			if (cont) begin
				emit_unit({5'd0, seq_bits[4:0], b[5:0]}, 1'b0);
				clear_seq();
			end else begin
				emit_unit(REPLACEMENT, 1'b0);
				start_seq(b);
			end
		end else if (seq_len == LEN_THREE) begin
			if (!cont) begin
				emit_unit(REPLACEMENT, 1'b0);
				start_seq(b);
			end else if (seq_count == 2'd1) begin
				cp = {seq_bits[3:0], b[5:0], 6'd0};
				// Overlong forms and surrogates are caught on the second byte.
				if (cp[15:11] == 5'd0 || cp[15:11] == SURROGATE_TOP) begin
					emit_unit(REPLACEMENT, 1'b0);
					clear_seq();
					skip_cont = 1'b1;
				end else begin
					seq_bits  = cp;
					seq_count = 2'd2;
				end
			end else begin
				emit_unit(seq_bits | {10'd0, b[5:0]}, 1'b0);
				clear_seq();
			end
		end else if (seq_len == LEN_FOUR) begin
			if (seq_count >= 2'd3) begin
				emit_unit(16'h0000, 1'b1);
				clear_seq();
				stopped = 1'b1;
			end else begin
				seq_count = seq_count + 2'd1;
			end
		end else begin
			start_seq(b);
		end
		for (int i = 0; i < step_n; i++) begin
			r = step_units[i];
			r.last_of_run = (i == step_n - 1);
			pending_units.push_back(r);
		end
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	// Offers one transaction from a falling edge and returns at the falling edge after it
	// is accepted. Valid is only lowered when the sender chooses to idle.
	task automatic drive_item(logic eos, logic [7:0] value);
		while (src_idle > 0 && $urandom_range(99) < src_idle) begin
			in_if.valid = 1'b0;
			@(negedge clk);
		end
		// A fourth byte would halt the block, so until allowed it is sent as an end of stream.
		if (!halt_allowed && !eos && seq_len == LEN_FOUR && seq_count >= 2'd3)
			eos = 1'b1;
		in_if.valid         = 1'b1;
		in_if.byte_value    = value;
		in_if.end_of_stream = eos;
		do
			@(posedge clk);
		while (!in_if.ready);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] value);
		drive_item(1'b0, value);
	endtask

	task automatic send_end();
		drive_item(1'b1, 8'($urandom_range(255)));
	endtask

	task automatic test_directed_cases();
		src_idle  = 0;
		sink_idle = 0;
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h7F);
		// Invalid lead, then its continuation is swallowed.
		send_byte(8'h80); send_byte(8'hBF);
		send_byte(8'hC1); send_byte(8'h80);
		send_byte(8'hC2); send_byte(8'h80);
		send_byte(8'hDF); send_byte(8'hBF);
		send_byte(8'hE0); send_byte(8'hA0); send_byte(8'h80);
		send_byte(8'hE0); send_byte(8'h9F); send_byte(8'hBF);
		send_byte(8'hED); send_byte(8'hA0);
		send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
		// A bad continuation is taken as a new lead and gives a second result.
		send_byte(8'hC2); send_byte(8'h41);
		send_byte(8'hE1); send_byte(8'h80); send_byte(8'hC2);
		send_end();
		send_byte(8'hF0); send_byte(8'h90); send_byte(8'h80);
		send_end();
		send_byte(8'hFF);
		send_end();
		send_byte(8'h80);
		send_end();
	endtask

	task automatic test_random_stream(int src_pct, int sink_pct, int count);
		int          pick;
		int          target;
		logic [7:0]  lead;
		logic [7:0]  second;
		src_idle  = src_pct;
		sink_idle = sink_pct;
		target    = sent_items + count;
		while (sent_items < target) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				send_byte(($urandom_range(49) == 0) ? 8'h00 : 8'($urandom_range(127, 1)));
			end else if (pick < 48) begin
				send_byte(8'($urandom_range(8'hDF, 8'hC2)));
				send_byte(cont_byte());
			end else if (pick < 68) begin
				lead = 8'($urandom_range(8'hEF, 8'hE0));
				if (lead == 8'hE0)
					second = 8'($urandom_range(8'hBF, 8'hA0));
				else if (lead == 8'hED)
					second = 8'($urandom_range(8'h9F, 8'h80));
				else
					second = cont_byte();
				send_byte(lead);
				send_byte(second);
				send_byte(cont_byte());
			end else if (pick < 72) begin
				send_byte(8'($urandom_range(8'hF4, 8'hF0)));
				repeat ($urandom_range(3, 1))
					send_byte(8'($urandom_range(255)));
			end else if (pick < 78) begin
				if ($urandom_range(1))
					send_byte(8'($urandom_range(8'hC1, 8'h80)));
				else
					send_byte(8'($urandom_range(8'hFF, 8'hF5)));
				repeat ($urandom_range(3))
					send_byte(cont_byte());
			end else if (pick < 86) begin
				lead = 8'($urandom_range(8'hEF, 8'hC2));
				send_byte(lead);
				if (lead >= 8'hE0 && $urandom_range(1))
					send_byte(cont_byte());
				if ($urandom_range(1))
					send_end();
				else if ($urandom_range(1))
					send_byte(8'($urandom_range(127)));
				else
					send_byte(8'($urandom_range(8'hF4, 8'hC2)));
			end else if (pick < 91) begin
				if ($urandom_range(1)) begin
					send_byte(8'hE0);
					send_byte(8'($urandom_range(8'h9F, 8'h80)));
				end else begin
					send_byte(8'hED);
					send_byte(8'($urandom_range(8'hBF, 8'hA0)));
				end
				repeat ($urandom_range(2))
					send_byte(cont_byte());
			end else if (pick < 95) begin
				send_end();
			end else begin
				send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	// The receiver holds off while two-result pairs keep coming, so the result queue
	// fills and the input is stalled.
	task automatic test_output_stall();
		src_idle  = 0;
		sink_idle = 0;
		send_end();
		hold_reqs++;
		repeat (40) begin
			send_byte(8'($urandom_range(8'hDF, 8'hC2)));
			send_byte(8'($urandom_range(127, 1)));
		end
	endtask

	task automatic test_four_byte_halt();
		src_idle     = 10;
		sink_idle    = 30;
		halt_allowed = 1'b1;
		send_end();
		send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
		// Once halted, nothing is decoded, not even the end of stream.
		send_byte(8'h41);
		send_byte(8'hC2);
		send_end();
		send_byte(8'hFF);
	endtask

	// Receiver: random idling, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_if.ready = 1'b0;
			hold_left--;
		end else if (hold_seen != hold_reqs) begin
			hold_seen    = hold_reqs;
			hold_left    = HOLD_CYCLES - 1;
			out_if.ready = 1'b0;
		end else begin
			out_if.ready = ($urandom_range(99) >= sink_idle);
		end
	end

	// Predicts on each accepted byte, checks each accepted code unit, and watches for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_if.valid && in_if.ready)
				predict_units(in_if.byte_value, in_if.end_of_stream);
			if (out_if.valid && out_if.ready) begin
				if (pending_units.size() == 0) begin
					$display("%0t: unexpected result: expected none, got code_unit %h error %b last %b",
						$time, out_if.code_unit, out_if.decode_error, out_if.last_of_run);
					mismatches++;
				end else begin
					oldest = pending_units.pop_front();
					if (out_if.code_unit !== oldest.code_unit) begin
						$display("%0t: code_unit mismatch: expected %h, got %h",
							$time, oldest.code_unit, out_if.code_unit);
						mismatches++;
					end
					if (out_if.decode_error !== oldest.decode_error) begin
						$display("%0t: decode_error mismatch: expected %b, got %b",
							$time, oldest.decode_error, out_if.decode_error);
						mismatches++;
					end
					if (out_if.last_of_run !== oldest.last_of_run) begin
						$display("%0t: last_of_run mismatch: expected %b, got %b",
							$time, oldest.last_of_run, out_if.last_of_run);
						mismatches++;
					end
				end
			end
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		in_if.valid         = 1'b0;
		in_if.byte_value    = 8'h00;
		in_if.end_of_stream = 1'b0;
		mismatches   = 0;
		sent_items   = 0;
		idle_cycles  = 0;
		src_idle     = 0;
		sink_idle    = 0;
		hold_reqs    = 0;
		hold_seen    = 0;
		hold_left    = 0;
		halt_allowed = 1'b0;
		stopped      = 1'b0;
		skip_cont    = 1'b0;
		clear_seq();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_stream(23, 60, 490);
		test_random_stream(60, 23, 490);
		test_random_stream(0, 0, 490);
		test_output_stall();
		test_four_byte_halt();

		in_if.valid = 1'b0;
		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
